### hdl/assert_macros.svh
// assertion macros shared by the compensation block
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bsc assertion failed");

// antecedent implies consequent in the next cycle
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bsc assertion failed");

`endif

### hdl/bsc_pkg.sv
// types, constants and codes of the barometric compensation block
// no dependencies
package bsc_pkg;

    // built-in scale factors
    localparam logic [23:0] STD_TEMP_SCALE  = 24'd524288;
    localparam logic [23:0] STD_PRESS_SCALE = 24'd524288;
    localparam logic [23:0] MIN_SCALE       = 24'd65536;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_COEFF_LOW  = 3'd0,
        REG_COEFF_MID  = 3'd1,
        REG_COEFF_HIGH = 3'd2,
        REG_TEMP_SCALE = 3'd3,
        REG_PRESS_SCALE = 3'd4,
        REG_USE_STD    = 3'd5
    } t_reg_idx;

    // multiply steps of the polynomial sequence
    typedef enum logic [3:0] {
        MOP_T1 = 4'd0,   // t*c1, a = c0/2 + m
        MOP_P1 = 4'd1,   // p*h, h = c20 + m
        MOP_P2 = 4'd2,   // p*h, h = c10 + m
        MOP_P3 = 4'd3,   // p*h, a = c00 + m
        MOP_P4 = 4'd4,   // p*c21, g = c11 + m
        MOP_P5 = 4'd5,   // t*c01, a = a + m
        MOP_P6 = 4'd6,   // t*p, h = m
        MOP_P7 = 4'd7    // h*g, a = a + m
    } t_mop;

    // configuration seen by the datapath
    typedef struct packed {
        logic [47:0] coeff_low;
        logic [47:0] coeff_mid;
        logic [47:0] coeff_high;
        logic [23:0] temp_scale;
        logic [23:0] press_scale;
        logic        use_std;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_start;
        logic wb;
        logic out_load;
        t_mop op;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic pressure;
        logic out_free;
    } t_sts;

endpackage

### hdl/bsc_req_if.sv
// request channel of the compensation block
// no dependencies
interface bsc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] raw_sample;

    modport source (output valid, output req_type, output raw_sample, input ready);
    modport sink   (input valid, input req_type, input raw_sample, output ready);
endinterface

### hdl/bsc_res_if.sv
// result channel of the compensation block
// no dependencies
interface bsc_res_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] compensated_value;
    logic signed [39:0] scaled_ratio;

    modport source (output valid, output result_kind, output compensated_value,
                    output scaled_ratio, input ready);
    modport sink   (input valid, input result_kind, input compensated_value,
                    input scaled_ratio, output ready);
endinterface

### hdl/bsc_ctrl.sv
// controller of the compensation block: sequences divide, multiply steps and output
// depends on bsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module bsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bsc_pkg::t_sts i_sts,
    output bsc_pkg::t_cmd o_cmd
);
    import bsc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_MLOAD = 6'b000100,
        S_MUL   = 6'b001000,
        S_WB    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_mop   r_op, n_op;

    // next op in the pressure sequence
    function automatic t_mop next_op(input t_mop op);
        t_mop nx;
        case (op)
            MOP_P1:  nx = MOP_P2;
            MOP_P2:  nx = MOP_P3;
            MOP_P3:  nx = MOP_P4;
            MOP_P4:  nx = MOP_P5;
            MOP_P5:  nx = MOP_P6;
            MOP_P6:  nx = MOP_P7;
            default: nx = MOP_T1;
        endcase
        return nx;
    endfunction

    // state transitions and commands
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_op    = i_sts.pressure ? MOP_P1 : MOP_T1;
                    n_state = S_MLOAD;
                end
            end
            S_MLOAD: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (r_op == MOP_T1 || r_op == MOP_P7) begin
                    n_state = S_DONE;
                end else begin
                    n_op    = next_op(r_op);
                    n_state = S_MLOAD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= MOP_T1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    `BSC_ASSERT_NEXT(a_accept_starts_div, o_cmd.accept, r_state == S_DIV)
    `BSC_ASSERT_IMPL(a_div_done_in_div, i_sts.div_done, r_state == S_DIV)
    `BSC_ASSERT_IMPL(a_mul_done_in_mul, i_sts.mul_done, r_state == S_MUL)

endmodule

### hdl/bsc_dp.sv
// datapath of the compensation block: serial divider, serial multiplier,
// accumulators and output register
// depends on bsc_pkg
module bsc_dp #(
    parameter logic [23:0] P_STD_TEMP_SCALE  = bsc_pkg::STD_TEMP_SCALE,
    parameter logic [23:0] P_STD_PRESS_SCALE = bsc_pkg::STD_PRESS_SCALE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bsc_pkg::t_cfg      i_cfg,
    input  bsc_pkg::t_cmd      i_cmd,
    output bsc_pkg::t_sts      o_sts,
    input  logic               i_req_type,
    input  logic [23:0]        i_raw_sample,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_res_kind,
    output logic signed [31:0] o_res_value,
    output logic signed [39:0] o_res_ratio
);
    import bsc_pkg::*;

    localparam int DIV_STEPS = 54;
    localparam int MUL_STEPS = 64;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

    // coefficient unpacking
    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;
    assign c0  = i_cfg.coeff_low[47:36];
    assign c1  = i_cfg.coeff_low[35:24];
    assign c00 = i_cfg.coeff_low[23:4];
    assign c10 = {i_cfg.coeff_low[3:0], i_cfg.coeff_mid[47:32]};
    assign c01 = i_cfg.coeff_mid[31:16];
    assign c11 = i_cfg.coeff_mid[15:0];
    assign c20 = i_cfg.coeff_high[47:32];
    assign c21 = i_cfg.coeff_high[31:16];
    assign c30 = i_cfg.coeff_high[15:0];

    logic signed [63:0] c0_h, c1_q, c00_q, c10_q, c01_q, c11_q, c20_q, c21_q, c30_q;
    assign c0_h  = 64'(c0) <<< 29;
    assign c1_q  = 64'(c1) <<< 30;
    assign c00_q = 64'(c00) <<< 30;
    assign c10_q = 64'(c10) <<< 30;
    assign c01_q = 64'(c01) <<< 30;
    assign c11_q = 64'(c11) <<< 30;
    assign c20_q = 64'(c20) <<< 30;
    assign c21_q = 64'(c21) <<< 30;
    assign c30_q = 64'(c30) <<< 30;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    // item registers
    logic               r_kind;
    logic signed [39:0] r_p, r_t;
    logic signed [63:0] r_h, r_g, r_a;

    // divider
    logic        r_dbusy;
    logic [5:0]  r_dcnt;
    logic [23:0] r_d, r_rem;
    logic [53:0] r_dq;
    logic        r_dneg;

    logic [23:0] sel_scale, div_d, raw_mag;
    logic [24:0] trial;
    logic        ge;
    logic [24:0] trial_sub;
    logic [53:0] q_full;
    logic [39:0] q_mag;
    logic signed [39:0] ratio;
    logic        div_done;

    assign sel_scale = i_req_type ? (i_cfg.use_std ? P_STD_PRESS_SCALE : i_cfg.press_scale)
                                  : (i_cfg.use_std ? P_STD_TEMP_SCALE : i_cfg.temp_scale);
    assign div_d     = (sel_scale < MIN_SCALE) ? MIN_SCALE : sel_scale;
    assign raw_mag   = i_raw_sample[23] ? (~i_raw_sample + 24'd1) : i_raw_sample;
    assign trial     = {r_rem, r_dq[53]};
    assign ge        = (trial >= {1'b0, r_d});
    assign trial_sub = trial - {1'b0, r_d};
    assign q_full    = {r_dq[52:0], ge};
    assign q_mag     = q_full[39:0];
    assign ratio     = r_dneg ? signed'(~q_mag + 40'd1) : signed'(q_mag);
    assign div_done  = r_dbusy && (r_dcnt == 6'(DIV_STEPS - 1));

    // multiplier
    logic         r_mbusy, r_mrnd, r_mdone, r_mneg;
    logic [5:0]   r_mcnt;
    logic [63:0]  r_ma, r_mb;
    logic [127:0] r_prod;
    logic signed [63:0] r_m;

    logic signed [63:0] mx, my;
    logic [127:0] prod_rnd;
    logic [62:0]  prod_q;
    logic signed [63:0] m_val;

    // operand selection of the current step
    always_comb begin
        case (i_cmd.op)
            MOP_T1:  begin mx = 64'(r_t); my = c1_q;        end
            MOP_P1,
            MOP_P2,
            MOP_P3:  begin mx = 64'(r_p); my = r_h;         end
            MOP_P4:  begin mx = 64'(r_p); my = c21_q;       end
            MOP_P5:  begin mx = 64'(r_t); my = c01_q;       end
            MOP_P6:  begin mx = 64'(r_t); my = 64'(r_p);    end
            MOP_P7:  begin mx = r_h;      my = r_g;         end
            default: begin mx = '0;       my = '0;          end
        endcase
    end

    // rounding and saturation of the product
    assign prod_rnd = r_prod + 128'(1 << 29);
    assign prod_q   = prod_rnd[92:30];
    always_comb begin
        if (|prod_rnd[127:93]) begin
            m_val = r_mneg ? S64_MIN : S64_MAX;
        end else if (r_mneg) begin
            m_val = signed'(~{1'b0, prod_q} + 64'd1);
        end else begin
            m_val = signed'({1'b0, prod_q});
        end
    end

    // control registers of the serial units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
            r_mbusy <= 1'b0;
            r_mrnd  <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
            r_t     <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (div_done) begin
                r_dbusy <= 1'b0;
                if (!r_kind) begin
                    r_t <= ratio;
                end
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 6'd1;
            end
            r_mdone <= r_mrnd;
            r_mrnd  <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 6'd1;
                if (r_mcnt == 6'(MUL_STEPS - 1)) begin
                    r_mbusy <= 1'b0;
                    r_mrnd  <= 1'b1;
                end
            end
        end
    end

    // payload registers of divider, multiplier and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_req_type;
            r_d    <= div_d;
            r_rem  <= '0;
            r_dq   <= {raw_mag, 30'd0} + 54'(div_d >> 1);
            r_dneg <= i_raw_sample[23];
            r_h    <= c30_q;
        end else if (r_dbusy) begin
            r_rem <= ge ? trial_sub[23:0] : trial[23:0];
            r_dq  <= q_full;
            if (div_done) begin
                r_p <= ratio;
            end
        end
        if (i_cmd.mul_start) begin
            r_ma   <= mag64(mx);
            r_mb   <= mag64(my);
            r_mneg <= mx[63] ^ my[63];
            r_prod <= '0;
        end else if (r_mbusy) begin
            r_prod <= (r_prod << 1) + (r_mb[63] ? {64'd0, r_ma} : 128'd0);
            r_mb   <= r_mb << 1;
        end
        if (r_mrnd) begin
            r_m <= m_val;
        end
        // write back of the finished step
        if (i_cmd.wb) begin
            case (i_cmd.op)
                MOP_T1:  r_a <= sadd(c0_h, r_m);
                MOP_P1:  r_h <= sadd(c20_q, r_m);
                MOP_P2:  r_h <= sadd(c10_q, r_m);
                MOP_P3:  r_a <= sadd(c00_q, r_m);
                MOP_P4:  r_g <= sadd(c11_q, r_m);
                MOP_P5:  r_a <= sadd(r_a, r_m);
                MOP_P6:  r_h <= r_m;
                MOP_P7:  r_a <= sadd(r_a, r_m);
                default: r_h <= r_h;
            endcase
        end
    end

    // q30 to q23.8 with rounding and saturation
    logic [63:0] a_mag;
    logic [64:0] a_rnd;
    logic [42:0] a_q;
    logic signed [31:0] q8;
    assign a_mag = mag64(r_a);
    assign a_rnd = {1'b0, a_mag} + 65'(1 << 21);
    assign a_q   = a_rnd[64:22];
    always_comb begin
        if (r_a[63]) begin
            q8 = (a_q > 43'h0_8000_0000) ? 32'sh8000_0000 : signed'(~a_q[31:0] + 32'd1);
        end else begin
            q8 = (a_q > 43'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(a_q[31:0]);
        end
    end

    // output register
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_res_kind  <= r_kind;
            o_res_value <= q8;
            o_res_ratio <= r_p;
        end
    end

    assign o_res_valid    = r_ovalid;
    assign o_sts.div_done = div_done;
    assign o_sts.mul_done = r_mdone;
    assign o_sts.pressure = r_kind;
    assign o_sts.out_free = !r_ovalid || i_res_ready;

endmodule

### hdl/baro_sensor_compensation.sv
// top level of the barometric compensation block: register port and channel wiring
// depends on bsc_pkg, bsc_req_if, bsc_res_if, bsc_ctrl and bsc_dp
//
//  channel   direction  payload
//  i_req     in         req_type, raw_sample
//  o_res     out        result_kind, compensated_value, scaled_ratio
//  apb       in/out     six registers at byte address 8*index
//
// one item at a time: the 54-step serial divider runs first, then the 64-step serial
// multiplier once per multiply step (one step for temperature, seven for pressure)
// sync active-low reset clears control state and last temperature ratio, presets registers
// a held result in the output register stalls only the final write, not the work before it
module baro_sensor_compensation #(
    parameter logic [23:0] STANDARD_TEMP_SCALE  = bsc_pkg::STD_TEMP_SCALE,
    parameter logic [23:0] STANDARD_PRESS_SCALE = bsc_pkg::STD_PRESS_SCALE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [5:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output logic [63:0] o_prdata,
    output logic        o_pready,
    bsc_req_if.sink     i_req,
    bsc_res_if.source   o_res
);
    import bsc_pkg::*;

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_sts     sts;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign o_pready = 1'b1;
    assign reg_idx  = t_reg_idx'(i_paddr[5:3]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff_low   <= '0;
            r_cfg.coeff_mid   <= '0;
            r_cfg.coeff_high  <= '0;
            r_cfg.temp_scale  <= 24'd524288;
            r_cfg.press_scale <= 24'd524288;
            r_cfg.use_std     <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COEFF_LOW:   r_cfg.coeff_low   <= i_pwdata[47:0];
                REG_COEFF_MID:   r_cfg.coeff_mid   <= i_pwdata[47:0];
                REG_COEFF_HIGH:  r_cfg.coeff_high  <= i_pwdata[47:0];
                REG_TEMP_SCALE:  r_cfg.temp_scale  <= i_pwdata[23:0];
                REG_PRESS_SCALE: r_cfg.press_scale <= i_pwdata[23:0];
                REG_USE_STD:     r_cfg.use_std     <= i_pwdata[0];
                default:         r_cfg.use_std     <= r_cfg.use_std;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            REG_COEFF_LOW:   o_prdata = 64'(r_cfg.coeff_low);
            REG_COEFF_MID:   o_prdata = 64'(r_cfg.coeff_mid);
            REG_COEFF_HIGH:  o_prdata = 64'(r_cfg.coeff_high);
            REG_TEMP_SCALE:  o_prdata = 64'(r_cfg.temp_scale);
            REG_PRESS_SCALE: o_prdata = 64'(r_cfg.press_scale);
            REG_USE_STD:     o_prdata = 64'(r_cfg.use_std);
            default:         o_prdata = '0;
        endcase
    end

    bsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bsc_dp #(
        .P_STD_TEMP_SCALE  (STANDARD_TEMP_SCALE),
        .P_STD_PRESS_SCALE (STANDARD_PRESS_SCALE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req.req_type),
        .i_raw_sample (i_req.raw_sample),
        .o_res_valid  (o_res.valid),
        .i_res_ready  (o_res.ready),
        .o_res_kind   (o_res.result_kind),
        .o_res_value  (o_res.compensated_value),
        .o_res_ratio  (o_res.scaled_ratio)
    );

endmodule
